/* rtl/ecvf_pkg.sv */
// ----------------------------------------------------------------------------
// Exact-count value filter package
// Shared widths and default settings for the exact-count value filter.
// ----------------------------------------------------------------------------
package ecvf_pkg;

	// Width of one list value and of one selected value.
	localparam int VALUE_W = 32;

	// Width of the target count register.
	localparam int TARGET_W = 5;

	// Target count after reset.
	localparam logic [TARGET_W-1:0] TARGET_RESET = 5'd1;

	// Default number of list entries that can be held.
	localparam int DEFAULT_CAPACITY = 16;

endpackage

/* rtl/ecvf_ram.sv */
// ----------------------------------------------------------------------------
// Exact-count value filter RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module ecvf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/exact_count_value_filter_unit.sv */
// ----------------------------------------------------------------------------
// Exact-count value filter
// Collects a list of signed values and reports each distinct value that
// occurs exactly target_count times, in order of first appearance.
// ----------------------------------------------------------------------------
// The block takes one list item per cycle while it is loading; the item with
// end_of_list set closes the list, and items beyond CAPACITY are dropped and
// flagged on every result of that run. After the closing item the block
// holds item_stall high while it selects: each of the L stored entries is
// fetched and then compared against all L entries through the single read
// port of the list memory. Results then leave through an output register one
// at a time, each read, loaded and held until the receiving side takes it; a
// run with no qualifying value gives one result with none_found set. No
// clearing pass is needed after reset. The target count register may only be
// written while the block is loading with no list in progress.
module exact_count_value_filter_unit #(
	parameter int CAPACITY = ecvf_pkg::DEFAULT_CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration
	input  logic                                cfg_write_en,
	input  logic [ecvf_pkg::TARGET_W-1:0]       cfg_write_data,
	// List items
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic signed [ecvf_pkg::VALUE_W-1:0] value,
	input  logic                                end_of_list,
	// Results
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [ecvf_pkg::VALUE_W-1:0] selected_value,
	output logic                                none_found,
	output logic                                overflowed,
	output logic                                last_result
);

	import ecvf_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > TARGET_W) ? CW : TARGET_W;
	localparam logic [CW-1:0] LEN_FULL = CW'(CAPACITY);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_LATCH,
		ST_SCAN,
		ST_DECIDE,
		ST_RD_SEL,
		ST_LD_OUT,
		ST_SEND
	} state_t;

	state_t               state_q;
	logic [TARGET_W-1:0]  target_q;
	logic [CW-1:0]        len_q;
	logic                 ovf_q;
	logic [CW-1:0]        sel_len_q;
	logic [CW-1:0]        i_q;
	logic [CW-1:0]        j_q;
	logic [CW-1:0]        k_q;
	logic [VALUE_W-1:0]   elem_q;
	logic [CW-1:0]        count_q;
	logic                 earlier_q;
	logic                 cmp_vld_s1;
	logic [CW-1:0]        j_s1;

	logic                 res_valid_q;
	logic [VALUE_W-1:0]   res_value_q;
	logic                 res_none_q;
	logic                 res_ovf_q;
	logic                 res_last_q;

	logic                 item_xfer;
	logic                 result_xfer;
	logic                 list_we;
	logic [AW-1:0]        list_raddr;
	logic [VALUE_W-1:0]   list_rdata;
	logic                 hit;
	logic [CW-1:0]        i_next;
	logic [CW-1:0]        sel_len_next;
	logic [VALUE_W-1:0]   sel_rdata;

	assign item_stall  = (state_q != ST_LOAD);
	assign item_xfer   = item_valid && (state_q == ST_LOAD);
	assign result_xfer = res_valid_q && !result_stall;

	// Store the item while there is room; a full list drops it.
	assign list_we = item_xfer && (len_q != LEN_FULL);

	// The entry under test is fetched at index i, the scan walks index j.
	assign list_raddr = (state_q == ST_FETCH) ? i_q[AW-1:0] : j_q[AW-1:0];

	// A value qualifies on its first appearance with the exact count.
	assign hit = !earlier_q && (CMPW'(count_q) == CMPW'(target_q));
	assign i_next = CW'(i_q + 1'b1);
	assign sel_len_next = hit ? CW'(sel_len_q + 1'b1) : sel_len_q;

	ecvf_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_list_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (len_q[AW-1:0]),
		.wdata ($unsigned(value)),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

	// Selected values are written during the decision step and read only
	// after the scan ends, so the two ports never touch the same entry at once.
	ecvf_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_sel_ram (
		.clk   (clk),
		.we    ((state_q == ST_DECIDE) && hit),
		.waddr (sel_len_q[AW-1:0]),
		.wdata (elem_q),
		.raddr (k_q[AW-1:0]),
		.rdata (sel_rdata)
	);

	// Target count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg_write_en) begin
			target_q <= cfg_write_data;
		end
	end

	// Sequencer: load, scan, decide and send results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			sel_len_q   <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			count_q     <= '0;
			earlier_q   <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			j_s1        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= 1'b0;

			// Compare stage of the scan: count matches, note earlier ones.
			if (cmp_vld_s1 && (list_rdata == elem_q)) begin
				count_q <= CW'(count_q + 1'b1);
				if (j_s1 < i_q) begin
					earlier_q <= 1'b1;
				end
			end

			case (state_q)
				ST_LOAD: begin
					if (item_xfer) begin
						if (len_q != LEN_FULL) begin
							len_q <= CW'(len_q + 1'b1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (end_of_list) begin
							i_q       <= '0;
							sel_len_q <= '0;
							state_q   <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					j_q     <= '0;
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					elem_q    <= list_rdata;
					count_q   <= '0;
					earlier_q <= 1'b0;
					state_q   <= ST_SCAN;
					if (j_q != len_q) begin
						cmp_vld_s1 <= 1'b1;
						j_s1       <= j_q;
						j_q        <= CW'(j_q + 1'b1);
					end
				end
				ST_SCAN: begin
					if (j_q != len_q) begin
						cmp_vld_s1 <= 1'b1;
						j_s1       <= j_q;
						j_q        <= CW'(j_q + 1'b1);
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					sel_len_q <= sel_len_next;
					i_q       <= i_next;
					if (i_next != len_q) begin
						state_q <= ST_FETCH;
					end else if (sel_len_next == '0) begin
						res_valid_q <= 1'b1;
						res_value_q <= '0;
						res_none_q  <= 1'b1;
						res_ovf_q   <= ovf_q;
						res_last_q  <= 1'b1;
						state_q     <= ST_SEND;
					end else begin
						k_q     <= '0;
						state_q <= ST_RD_SEL;
					end
				end
				ST_RD_SEL: begin
					state_q <= ST_LD_OUT;
				end
				ST_LD_OUT: begin
					res_valid_q <= 1'b1;
					res_value_q <= sel_rdata;
					res_none_q  <= 1'b0;
					res_ovf_q   <= ovf_q;
					res_last_q  <= (CW'(k_q + 1'b1) == sel_len_q);
					state_q     <= ST_SEND;
				end
				ST_SEND: begin
					if (result_xfer) begin
						res_valid_q <= 1'b0;
						if (res_last_q) begin
							len_q     <= '0;
							ovf_q     <= 1'b0;
							sel_len_q <= '0;
							state_q   <= ST_LOAD;
						end else begin
							k_q     <= CW'(k_q + 1'b1);
							state_q <= ST_RD_SEL;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign result_valid   = res_valid_q;
	assign selected_value = $signed(res_value_q);
	assign none_found     = res_none_q;
	assign overflowed     = res_ovf_q;
	assign last_result    = res_last_q;

endmodule

/* tb/sv/exact_count_value_filter_unit_tb.sv */
// ----------------------------------------------------------------------------
// Exact-count value filter testbench
// Loads lists of signed values into the filter and predicts, for each closed
// list, the distinct values that occur exactly the target count of times.
// Every returned selection is compared field by field with that prediction,
// across several target counts, overflowing lists and random flow control.
// ----------------------------------------------------------------------------
module exact_count_value_filter_unit_tb;

	import ecvf_pkg::*;

	localparam int CAP        = DEFAULT_CAPACITY;
	localparam int RANDOM_QTY = 450;
	localparam int SCAN_WAIT  = CAP * (CAP + 4) + 80;

	// One expected or observed selection.
	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      none;
		logic                      ovf;
		logic                      last;
	} selection_t;

	// Predicts the selections of each list and checks the returned ones.
	class selection_scoreboard;
		logic [TARGET_W-1:0]       target;
		logic signed [VALUE_W-1:0] entries[$];
		logic                      dropped;
		selection_t                awaited[$];
		int                        errors;

		function new();
			target  = TARGET_RESET;
			dropped = 1'b0;
			errors  = 0;
		endfunction

		function void set_target(input logic [TARGET_W-1:0] t);
			target = t;
		endfunction

		task report(input string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Notes one accepted list item; the closing item computes the selections.
		function void note_list_item(input logic signed [VALUE_W-1:0] v, input logic closing);
			logic signed [VALUE_W-1:0] picked[$];
			selection_t                s;
			int                        hits;
			bit                        seen;
			if (entries.size() < CAP)
				entries.push_back(v);
			else
				dropped = 1'b1;
			if (!closing)
				return;
			foreach (entries[i]) begin
				seen = 0;
				hits = 0;
				foreach (picked[j])
					if (picked[j] == entries[i])
						seen = 1;
				foreach (entries[j])
					if (entries[j] == entries[i])
						hits++;
				if (!seen && hits == int'(target))
					picked.push_back(entries[i]);
			end
			if (picked.size() == 0) begin
				s.value = '0;
				s.none  = 1'b1;
				s.ovf   = dropped;
				s.last  = 1'b1;
				awaited.push_back(s);
			end else begin
				foreach (picked[i]) begin
					s.value = picked[i];
					s.none  = 1'b0;
					s.ovf   = dropped;
					s.last  = (i == picked.size() - 1);
					awaited.push_back(s);
				end
			end
			entries.delete();
			dropped = 1'b0;
		endfunction

		// Compares one returned selection with the oldest prediction.
		task check_selection(input selection_t got);
			selection_t want;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected selection value=%0d none=%b ovf=%b last=%b",
					got.value, got.none, got.ovf, got.last));
				return;
			end
			want = awaited.pop_front();
			if (got.value !== want.value)
				report($sformatf("selected_value %0d, predicted %0d", got.value, want.value));
			if (got.none !== want.none)
				report($sformatf("none_found %b, predicted %b", got.none, want.none));
			if (got.ovf !== want.ovf)
				report($sformatf("overflowed %b, predicted %b", got.ovf, want.ovf));
			if (got.last !== want.last)
				report($sformatf("last_result %b, predicted %b", got.last, want.last));
		endtask
	endclass

	logic                      clk            = 1'b0;
	logic                      arst_n         = 1'b0;
	logic                      cfg_write_en   = 1'b0;
	logic [TARGET_W-1:0]       cfg_write_data = '0;
	logic                      item_valid     = 1'b0;
	logic                      item_stall;
	logic signed [VALUE_W-1:0] value          = '0;
	logic                      end_of_list    = 1'b0;
	logic                      result_valid;
	logic                      result_stall   = 1'b0;
	logic signed [VALUE_W-1:0] selected_value;
	logic                      none_found;
	logic                      overflowed;
	logic                      last_result;

	selection_scoreboard sb;
	bit                  quiet_run = 1'b0;
	int                  stall_hold = 0;

	exact_count_value_filter_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.value          (value),
		.end_of_list    (end_of_list),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.selected_value (selected_value),
		.none_found     (none_found),
		.overflowed     (overflowed),
		.last_result    (last_result)
	);

	always #10 clk = ~clk;

	// The receiver alternates between open stretches, short stalls and rare long stalls.
	always @(posedge clk) begin : result_stall_gen
		int unsigned roll;
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				result_stall <= 1'b0;
				stall_hold   <= $urandom_range(0, 8);
			end else if (roll < 95) begin
				result_stall <= 1'b1;
				stall_hold   <= $urandom_range(0, 3);
			end else begin
				result_stall <= 1'b1;
				stall_hold   <= $urandom_range(10, 40);
			end
		end
	end

	// Every completed result transfer goes to the scoreboard.
	always @(posedge clk) begin : selection_monitor
		selection_t got;
		if (arst_n && result_valid && !result_stall) begin
			got.value = selected_value;
			got.none  = none_found;
			got.ovf   = overflowed;
			got.last  = last_result;
			sb.check_selection(got);
		end
	end

	// Sender gap: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int unsigned roll;
		if (quiet_run)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// A random value with the extremes of the field weighted in.
	function automatic logic signed [VALUE_W-1:0] fresh_value();
		case ($urandom_range(0, 19))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sh0000_0000;
			3:       return -32'sd1;
			4:       return 32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Offers one list item and waits for its transfer; the payload holds while stalled.
	task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic closing);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		value       <= v;
		end_of_list <= closing;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_list_item(v, closing);
	endtask

	task automatic send_list(input logic signed [VALUE_W-1:0] vals[$]);
		foreach (vals[i])
			send_item(vals[i], i == vals.size() - 1);
	endtask

	// Holds the sender until every predicted selection has come back.
	task automatic settle_pipeline();
		item_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Changes the target count while the filter is idle.
	task automatic write_target(input int t);
		settle_pipeline();
		cfg_write_en   <= 1'b1;
		cfg_write_data <= t[TARGET_W-1:0];
		@(posedge clk);
		cfg_write_en   <= 1'b0;
		sb.set_target(t[TARGET_W-1:0]);
	endtask

	// Mostly lists with values repeated exactly t times, plus noise, some overflowing.
	task automatic build_list(input int t, output logic signed [VALUE_W-1:0] vals[$]);
		logic signed [VALUE_W-1:0] pool[$];
		logic signed [VALUE_W-1:0] v;
		int                        groups;
		int                        noise;
		int                        j;
		vals.delete();
		if (t >= 1 && t <= CAP && $urandom_range(0, 99) < 75) begin
			groups = $urandom_range(1, CAP / t);
			for (int k = 0; k < groups; k++) begin
				v = fresh_value();
				repeat (t) vals.push_back(v);
			end
			noise = $urandom_range(0, CAP - groups * t);
			if (noise > 4)
				noise = $urandom_range(0, 4);
			repeat (noise) begin
				if ($urandom_range(0, 1) == 0)
					vals.push_back(vals[$urandom_range(0, vals.size() - 1)]);
				else
					vals.push_back(fresh_value());
			end
		end else begin
			repeat ($urandom_range(1, 4)) pool.push_back(fresh_value());
			repeat ($urandom_range(1, 12))
				vals.push_back(pool[$urandom_range(0, pool.size() - 1)]);
		end
		if ($urandom_range(0, 9) == 0) begin
			while (vals.size() < CAP + 1)
				vals.push_back(fresh_value());
			repeat ($urandom_range(0, 3)) vals.push_back(fresh_value());
		end
		for (int k = vals.size() - 1; k > 0; k--) begin
			j       = $urandom_range(0, k);
			v       = vals[k];
			vals[k] = vals[j];
			vals[j] = v;
		end
	endtask

	// Main stimulus: directed lists under the reset target, then random phases.
	initial begin : stimulus
		logic signed [VALUE_W-1:0] vals[$];
		int                        target_plan[8];
		int                        sent;
		int                        phase;
		int                        lists_in_phase;
		int                        t;
		sb          = new();
		target_plan = '{0, CAP, 2, 3, 1, 4, CAP - 1, 8};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A single most-negative value is selected on its own.
		vals = '{32'sh8000_0000};
		send_list(vals);
		// The repeated maximum is skipped, zero and minus one are selected.
		vals = '{32'sh7FFF_FFFF, 32'sh0000_0000, -32'sd1, 32'sh7FFF_FFFF};
		send_list(vals);
		// Nothing occurs once, so a single none result comes back.
		vals = '{32'sd5, 32'sd5, 32'sd5};
		send_list(vals);
		// A full list of distinct values and a dropped closing item.
		vals.delete();
		for (int k = 0; k < CAP; k++)
			vals.push_back(k * 3);
		vals.push_back(32'sd99);
		send_list(vals);

		sent           = 0;
		phase          = 0;
		lists_in_phase = 5;
		t              = TARGET_RESET;
		while (sent < RANDOM_QTY) begin
			if (lists_in_phase >= 5) begin
				t = (phase < 8) ? target_plan[phase] : $urandom_range(0, CAP);
				write_target(t);
				phase++;
				lists_in_phase = 0;
			end
			quiet_run = ($urandom_range(0, 3) == 0);
			build_list(t, vals);
			send_list(vals);
			sent += vals.size();
			lists_in_phase++;
			if ($urandom_range(0, 9) == 0)
				settle_pipeline();
		end

		settle_pipeline();
		repeat (SCAN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin : watchdog
		#(20 * 1000000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
